// ===== rtl/sha256_pkg.sv =====
package sha256_pkg;

  // One message transaction on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_item_t;

  // One digest word transaction on the output channel.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  // Eight 32-bit hash words; index 0 is the top digest word (a / H0).
  typedef logic [7:0][31:0] hash_words_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       load_byte;
    logic [7:0] byte_val;
    logic       start;
    logic       round;
    logic [5:0] round_idx;
  } round_ctl_t;

  // Padding marker byte and the block offset where the bit length begins.
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  // Initial hash values, written H7 first so that index 0 holds H0.
  localparam hash_words_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Round constants.
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== rtl/sha256_round_unit.sv =====
module sha256_round_unit (
  input  logic                    clk,
  input  sha256_pkg::round_ctl_t  ctl,
  input  sha256_pkg::hash_words_t chain,
  output sha256_pkg::hash_words_t work
);

  // Sixteen-word window: bytes shift in at the bottom while a block is
  // collected, and during the rounds it slides one schedule word per cycle.
  // The oldest word sits in the top 32 bits.
  logic [511:0] sched;
  logic [31:0]  w_cur;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  a_val;
  logic [31:0]  e_val;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  // Schedule word and round arithmetic for the current round.
  always_comb begin
    a_val = work[0];
    e_val = work[4];
    w_cur = sched[511:480];
    w_new = w_cur
          + (rotr(sched[479:448], 7) ^ rotr(sched[479:448], 18) ^ (sched[479:448] >> 3))
          + sched[223:192]
          + (rotr(sched[63:32], 17) ^ rotr(sched[63:32], 19) ^ (sched[63:32] >> 10));
    t1 = work[7] + (rotr(e_val, 6) ^ rotr(e_val, 11) ^ rotr(e_val, 25))
       + ((e_val & work[5]) ^ (~e_val & work[6]))
       + sha256_pkg::ROUND_K[ctl.round_idx] + w_cur;
    t2 = (rotr(a_val, 2) ^ rotr(a_val, 13) ^ rotr(a_val, 22))
       + ((a_val & work[1]) ^ (a_val & work[2]) ^ (work[1] & work[2]));
  end

  // Message window update.
  always_ff @(posedge clk) begin
    if (ctl.load_byte) begin
      sched <= {sched[503:0], ctl.byte_val};
    end else if (ctl.round) begin
      sched <= {sched[479:0], w_new};
    end
  end

  // Working variables: loaded from the chaining words, then one round a cycle.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      work <= chain;
    end else if (ctl.round) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

endmodule

// ===== rtl/sha256_stream_hasher_top.sv =====
// SHA-256 stream hasher.
// The msg channel takes one transaction per message byte (byte_present set),
// or an empty transaction. A transaction with end_of_message set closes the
// message, after its byte if it carries one; an empty message is allowed.
// The digest channel then delivers eight transactions, word_index 0 (most
// significant) to 7, with last_word set on the eighth.
// Timing: a byte that does not complete a 64-byte block is taken without a
// stall. A byte that completes one holds msg_stall high through the
// compression: 64 rounds through the shared round unit, one round per cycle,
// then a final step that adds into the chaining words. At end of message the
// sequencer pushes the padding bytes one per cycle (64 - fill, or 128 - fill
// when fill >= 56), compressing each full block, then the digest words appear,
// one per cycle unless the receiver stalls. While the digest channel is stalled
// the word holds and msg_stall stays high. After the last word the chaining
// words return to the initial values and the next message can start.
// Reset clears the sequencer, length and fill counters and loads the initial
// hash values; it takes effect at the next clock edge.
module sha256_stream_hasher_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     msg_valid,
  output logic                     msg_stall,
  input  sha256_pkg::msg_item_t    msg_item,
  output logic                     digest_valid,
  input  logic                     digest_stall,
  output sha256_pkg::digest_item_t digest_item
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_FINAL = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]              state;
  logic [5:0]              round_idx;
  logic [5:0]              fill;
  logic [60:0]             msg_len;
  logic [60:0]             msg_len_next;
  logic [63:0]             len_sr;
  logic                    pad_active;
  logic                    pad_first;
  logic                    need_wrap;
  logic                    last_block;
  logic [2:0]              out_idx;
  sha256_pkg::hash_words_t chain;
  sha256_pkg::hash_words_t work;
  sha256_pkg::round_ctl_t  ctl;

  logic       accept;
  logic       pad_push;
  logic       push;
  logic       wrap;
  logic [7:0] pad_byte;

  // Byte source selection and block completion.
  always_comb begin
    accept       = msg_valid && !msg_stall;
    pad_push     = (state == ST_PAD);
    push         = (accept && msg_item.byte_present) || pad_push;
    wrap         = push && (fill == '1);
    msg_len_next = msg_len + 61'(accept && msg_item.byte_present);
    priority if (pad_first) begin
      pad_byte = sha256_pkg::PAD_MARK;
    end else if (need_wrap || (fill < sha256_pkg::LEN_POS)) begin
      pad_byte = '0;
    end else begin
      pad_byte = len_sr[63:56];
    end
    ctl.load_byte = push;
    ctl.byte_val  = pad_push ? pad_byte : msg_item.data_byte;
    ctl.start     = wrap;
    ctl.round     = (state == ST_ROUND);
    ctl.round_idx = round_idx;
  end

  assign msg_stall    = (state != ST_IDLE);
  assign digest_valid = (state == ST_OUT);

  // Output words come straight from the chaining registers.
  always_comb begin
    digest_item.digest_word = chain[out_idx];
    digest_item.word_index  = out_idx;
    digest_item.last_word   = (out_idx == '1);
  end

  sha256_round_unit u_round (
    .clk   (clk),
    .ctl   (ctl),
    .chain (chain),
    .work  (work)
  );

  // Sequencer, counters and chaining words.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      round_idx  <= '0;
      fill       <= '0;
      msg_len    <= '0;
      pad_active <= 1'b0;
      pad_first  <= 1'b0;
      need_wrap  <= 1'b0;
      last_block <= 1'b0;
      out_idx    <= '0;
      chain      <= sha256_pkg::INIT_H;
    end else begin
      if (push) begin
        fill <= fill + 6'd1;
      end
      msg_len <= msg_len_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (msg_item.end_of_message) begin
              pad_active <= 1'b1;
              pad_first  <= 1'b1;
              need_wrap  <= 1'b0;
              last_block <= 1'b0;
              len_sr     <= {msg_len_next, 3'b000};
            end
            if (wrap) begin
              state     <= ST_ROUND;
              round_idx <= '0;
            end else if (msg_item.end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          priority if (pad_first) begin
            pad_first <= 1'b0;
            if ((fill >= sha256_pkg::LEN_POS) && !wrap) begin
              need_wrap <= 1'b1;
            end
          end else if (need_wrap || (fill < sha256_pkg::LEN_POS)) begin
            if (wrap) begin
              need_wrap <= 1'b0;
            end
          end else begin
            len_sr <= {len_sr[55:0], 8'h00};
            if (wrap) begin
              last_block <= 1'b1;
            end
          end
          if (wrap) begin
            state     <= ST_ROUND;
            round_idx <= '0;
          end
        end
        ST_ROUND: begin
          round_idx <= round_idx + 6'd1;
          if (round_idx == '1) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (last_block) begin
            state   <= ST_OUT;
            out_idx <= '0;
          end else if (pad_active) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (!digest_stall) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == '1) begin
              chain      <= sha256_pkg::INIT_H;
              msg_len    <= '0;
              pad_active <= 1'b0;
              last_block <= 1'b0;
              state      <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The digest is only shown once the final block has been folded in.
  a_out_fill_zero: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (fill == '0) && last_block)
    else $error("digest shown with a partial block");

  // Every compression starts at round zero.
  a_round_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) && ($past(state) != ST_ROUND) |-> (round_idx == '0))
    else $error("compression started mid-schedule");

  // The second-block zero run only exists inside padding.
  a_wrap_in_pad: assert property (@(posedge clk) disable iff (rst)
    need_wrap |-> pad_active && !pad_first)
    else $error("padding flags inconsistent");

  // After the last digest transaction the block takes a new message.
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_stall && digest_item.last_word |=> !msg_stall)
    else $error("not ready after digest");
`endif

endmodule
